@@ hw/rtl/bfhd_pkg.sv @@
package bfhd_pkg;

    // Number of battery packs held in the store.
    localparam int PACK_COUNT = 3;
    localparam int PACK_IDX_W = (PACK_COUNT > 1) ? $clog2(PACK_COUNT) : 1;
    localparam int PACK_OUT_W = 2;
    localparam logic [PACK_IDX_W-1:0] LAST_IDX = PACK_IDX_W'(PACK_COUNT - 1);

    // Half-float field masks and single-precision constants.
    localparam logic [15:0] HALF_SIGN_MASK = 16'h8000;
    localparam logic [15:0] HALF_EXP_MASK  = 16'h7C00;
    localparam logic [15:0] HALF_FRAC_MASK = 16'h03FF;
    localparam logic [4:0]  HALF_EXP_MAX   = 5'h1F;
    localparam logic [31:0] SINGLE_INF     = 32'h7F80_0000;
    localparam logic [7:0]  EXP_REBIAS     = 8'd112;
    localparam logic [7:0]  SUBN_REBIAS    = 8'd103;
    localparam logic [3:0]  HALF_FRAC_W    = 4'd10;

    // Request kinds on the input channel.
    localparam logic MODE_FRAME  = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  pack_number;
        logic [15:0] voltage_half;
        logic [15:0] current_half;
    } bfhd_in_t;

    typedef struct packed {
        logic [PACK_OUT_W-1:0] pack_out;
        logic [31:0]           voltage_single;
        logic [31:0]           current_single;
        logic                  last_entry;
    } bfhd_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_EMIT
    } bfhd_state_t;

    typedef struct packed {
        logic                  capture;
        logic                  store_wr;
        logic                  out_load;
        logic                  out_last;
        logic [PACK_IDX_W-1:0] rd_idx;
    } bfhd_cmd_t;

    typedef struct packed {
        logic slot_free;
    } bfhd_sts_t;

    // Widen a half-precision pattern to single precision; NaN becomes +0.
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic        sign;
        logic [4:0]  expo;
        logic [9:0]  frac;
        logic [3:0]  top;
        logic [9:0]  norm;
        logic [31:0] res;
        sign = (h & HALF_SIGN_MASK) != 16'h0;
        expo = h[14:10];
        frac = h[9:0];
        top  = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (frac[i])
            begin
                top = 4'(i);
            end
        end
        norm = 10'(frac << (HALF_FRAC_W - top));
        if (expo == 5'd0)
        begin
            if (frac == 10'd0)
            begin
                res = {sign, 31'd0};
            end
            else
            begin
                res = {sign, 8'({4'd0, top}) + SUBN_REBIAS, norm, 13'd0};
            end
        end
        else if (expo == HALF_EXP_MAX)
        begin
            if (frac != 10'd0)
            begin
                res = 32'd0;
            end
            else
            begin
                res = {sign, 31'd0} | SINGLE_INF;
            end
        end
        else
        begin
            res = {sign, 8'({3'd0, expo}) + EXP_REBIAS, frac, 13'd0};
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/bfhd_ctrl.sv @@
module bfhd_ctrl
    import bfhd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_mode,
    output logic      in_ready,
    input  bfhd_sts_t sts,
    output bfhd_cmd_t cmd
);

    bfhd_state_t           state_reg;
    bfhd_state_t           state_next;
    logic [PACK_IDX_W-1:0] idx_reg;
    logic [PACK_IDX_W-1:0] idx_next;
    logic                  accept;

    assign accept = (state_reg == ST_IDLE) && in_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_mode == MODE_REPORT) ? ST_EMIT : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sts.slot_free && (idx_reg == LAST_IDX))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.store_wr = 1'b0;
        cmd.out_load = 1'b0;
        cmd.out_last = (idx_reg == LAST_IDX);
        cmd.rd_idx   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_WRITE:
            begin
                cmd.store_wr = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.out_load = sts.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            idx_next = '0;
        end
        else if (cmd.out_load && (idx_reg != LAST_IDX))
        begin
            idx_next = idx_reg + PACK_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_mode == MODE_REPORT)) |=> (state_reg == ST_EMIT && idx_reg == '0))
        else $error("report request did not start at entry zero");

    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> (state_reg == ST_IDLE))
        else $error("store write lasted more than one cycle");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_last) |=> (state_reg == ST_IDLE))
        else $error("report run did not end after last entry");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("entry index out of range");

endmodule

@@ hw/rtl/bfhd_datapath.sv @@
module bfhd_datapath
    import bfhd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bfhd_in_t  in_data,
    input  bfhd_cmd_t cmd,
    output bfhd_sts_t sts,
    output logic      out_valid,
    input  logic      out_ready,
    output bfhd_out_t out_data
);

    logic                  slot_ok_reg;
    logic [PACK_IDX_W-1:0] slot_reg;
    logic [15:0]           volt_half_reg;
    logic [15:0]           curr_half_reg;
    logic [31:0]           volt_store_reg [PACK_COUNT];
    logic [31:0]           curr_store_reg [PACK_COUNT];
    logic                  out_valid_reg;
    logic                  out_valid_next;
    bfhd_out_t             out_data_reg;
    logic [PACK_IDX_W:0]   pack_num;
    logic                  slot_ok;

    assign slot_ok = (in_data.pack_number != 8'd0)
                  && (in_data.pack_number <= 8'(PACK_COUNT));

    // Capture the frame fields on accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ok_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            slot_ok_reg <= slot_ok && (in_data.mode == MODE_FRAME);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg      <= PACK_IDX_W'(in_data.pack_number - 8'd1);
            volt_half_reg <= in_data.voltage_half;
            curr_half_reg <= in_data.current_half;
        end
    end

    // Per-pack store, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PACK_COUNT; i++)
            begin
                volt_store_reg[i] <= 32'd0;
                curr_store_reg[i] <= 32'd0;
            end
        end
        else if (cmd.store_wr && slot_ok_reg)
        begin
            volt_store_reg[slot_reg] <= widen_half(volt_half_reg);
            curr_store_reg[slot_reg] <= widen_half(curr_half_reg);
        end
    end

    // Output register.
    assign sts.slot_free = !out_valid_reg || out_ready;
    assign pack_num      = {1'b0, cmd.rd_idx} + {{PACK_IDX_W{1'b0}}, 1'b1};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.pack_out       <= PACK_OUT_W'(pack_num);
            out_data_reg.voltage_single <= volt_store_reg[cmd.rd_idx];
            out_data_reg.current_single <= curr_store_reg[cmd.rd_idx];
            out_data_reg.last_entry     <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while held");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("stalled result dropped");

    a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.store_wr && slot_ok_reg) |-> (slot_reg <= LAST_IDX))
        else $error("store write outside pack range");

endmodule

@@ hw/rtl/battery_frame_half_float_decoder_unit.sv @@
// Battery frame decoder with half-to-single float widening.
// Input channel (in_valid/in_ready/in_data): each request is either a frame
// (mode 0) carrying a pack number and two half-precision values, or a report
// tick (mode 1). Frames for packs 1..PACK_COUNT are widened to single
// precision and stored (NaN stores as +0); other pack numbers are dropped.
// Output channel (out_valid/out_ready/out_data): a report tick emits one
// entry per pack, in pack order, with last_entry set on the final one.
// Sequence: a frame is captured on accept, then converted and stored. A
// report is accepted, then the sequencer steps one store entry per cycle
// into the single output register while the receiver keeps out_ready high.
// A frame produces no output. The block takes a new request as soon as the
// previous one has finished, even while the last result still waits in the
// output register.
// Stall: when out_ready is low the output register holds its entry and the
// sequencer waits; no entry is lost or repeated.
// Reset (rst_n low, asynchronous): clear all stored values to zero, empty
// the output register and return the controller to idle.
module battery_frame_half_float_decoder_unit
    import bfhd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  bfhd_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output bfhd_out_t out_data
);

    bfhd_cmd_t cmd;
    bfhd_sts_t sts;

    // Controller: sequence frame writes and report readout.
    bfhd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (in_data.mode),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: capture, float widening, pack store and output register.
    bfhd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
